/* rtl/ipv4_lpm_pkg.sv */
// ----------------------------------------------------------------------------
// ipv4_lpm_pkg
// Shared types and codes for the IPv4 longest prefix match unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4_lpm_pkg;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef struct packed {
      logic        func;
      logic [9:0]  entry_index;
      logic [31:0] address;
      logic [31:0] entry_mask;
      logic [31:0] entry_next_hop;
      logic [3:0]  entry_port;
   } ipv4_lpm_req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] gateway;
      logic [3:0]  out_port;
      logic [9:0]  match_index;
   } ipv4_lpm_rsp_type;

   typedef struct packed {
      logic [31:0] prefix;
      logic [31:0] mask;
      logic [31:0] gateway;
      logic [3:0]  port;
   } ipv4_lpm_entry_type;

endpackage

`default_nettype wire

/* rtl/ipv4_lpm_front.sv */
// ----------------------------------------------------------------------------
// ipv4_lpm_front
// Accepts request items, drops writes aimed beyond the table, and holds the
// rest in a two-entry queue toward the lookup engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_lpm_front #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire ipv4_lpm_pkg::ipv4_lpm_req_type req_data,
   output logic                                q_valid,
   output ipv4_lpm_pkg::ipv4_lpm_req_type      q_item,
   input  wire logic                           q_pop
);
   import ipv4_lpm_pkg::*;

   ipv4_lpm_req_type q_mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       accept;
   logic       keep;
   logic       push;
   logic       pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign keep      = (req_data.func == FUNC_LOOKUP) ||
                      ({22'd0, req_data.entry_index} < 32'(TABLE_DEPTH));
   assign push      = accept && keep;
   assign pop       = q_pop && (cnt_ff != 2'd0);

   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= req_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/ipv4_lpm_back.sv */
// ----------------------------------------------------------------------------
// ipv4_lpm_back
// Route table memory and scan engine: stores write items and scans the
// in-use entries one per cycle for a lookup, keeping the best match.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_lpm_back #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [10:0]                    entries_in_use,
   input  wire logic                           q_valid,
   input  wire ipv4_lpm_pkg::ipv4_lpm_req_type q_item,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output ipv4_lpm_pkg::ipv4_lpm_rsp_type      rsp_data
);
   import ipv4_lpm_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_WAIT   = 2'd2;
   localparam logic [1:0] ST_RESULT = 2'd3;

   ipv4_lpm_entry_type route_mem [TABLE_DEPTH];
   ipv4_lpm_entry_type rd_data_ff;
   ipv4_lpm_entry_type wr_entry;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      key_ff, key_in;
   logic [31:0]      best_mask_ff, best_mask_in;
   logic [31:0]      best_nh_ff, best_nh_in;
   logic [3:0]       best_port_ff, best_port_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   ipv4_lpm_rsp_type rsp_data_ff, rsp_data_in;
   logic             rsp_load;
   logic             start;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_idx_wide;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             is_last;
   logic             is_match;
   logic             is_better;
   logic [31:0]      best_idx_wide;

   assign count = (32'(entries_in_use) > 32'(TABLE_DEPTH)) ?
                  CNT_W'(TABLE_DEPTH) : CNT_W'(entries_in_use);

   assign start       = (state_ff == ST_IDLE) && q_valid;
   assign q_pop       = start;
   assign wr_en       = start && (q_item.func == FUNC_WRITE);
   assign wr_idx_wide = {22'd0, q_item.entry_index};
   assign wr_addr     = wr_idx_wide[IDX_W-1:0];
   assign wr_entry    = '{prefix:   q_item.address,
                          mask:     q_item.entry_mask,
                          gateway:  q_item.entry_next_hop,
                          port:     q_item.entry_port};

   assign rd_en   = (state_ff == ST_SCAN);
   assign rd_addr = idx_ff[IDX_W-1:0];
   assign is_last = (CNT_W'(idx_ff + 1'b1) == count);

   assign is_match  = ((key_ff & rd_data_ff.mask) == rd_data_ff.prefix);
   assign is_better = !found_ff || (rd_data_ff.mask > best_mask_ff);

   assign rsp_load      = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);
   assign best_idx_wide = 32'(best_idx_ff);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      best_mask_in = best_mask_ff;
      best_nh_in   = best_nh_ff;
      best_port_in = best_port_ff;
      best_idx_in  = best_idx_ff;
      cmp_vld_in   = rd_en;
      cmp_idx_in   = rd_addr;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (cmp_vld_ff && is_match && is_better) begin
         found_in     = 1'b1;
         best_mask_in = rd_data_ff.mask;
         best_nh_in   = rd_data_ff.gateway;
         best_port_in = rd_data_ff.port;
         best_idx_in  = cmp_idx_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start && (q_item.func == FUNC_LOOKUP)) begin
               key_in       = q_item.address;
               idx_in       = '0;
               found_in     = 1'b0;
               best_mask_in = '0;
               best_nh_in   = '0;
               best_port_in = '0;
               best_idx_in  = '0;
               state_in     = (count == '0) ? ST_RESULT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (is_last) begin
               state_in = ST_WAIT;
            end else begin
               idx_in = CNT_W'(idx_ff + 1'b1);
            end
         end
         ST_WAIT: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{hit:         found_ff,
                                gateway:     best_nh_ff,
                                out_port:    best_port_ff,
                                match_index: best_idx_wide[9:0]};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      key_ff       <= key_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_mask_ff <= best_mask_in;
      best_nh_ff   <= best_nh_in;
      best_port_ff <= best_port_in;
      best_idx_ff  <= best_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= route_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/ipv4_longest_prefix_match_unit.sv */
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_match_unit
// IPv4 route table with longest prefix match lookup.
// ----------------------------------------------------------------------------
// Write items store prefix, mask, next hop and port at a table slot and give
// no result; writes to a slot at or beyond TABLE_DEPTH are dropped. A lookup
// item scans slots 0 to entries_in_use-1 (capped at TABLE_DEPTH) and returns
// the matching entry with the largest mask, lowest slot on a tie, or a miss
// with all fields zero. The table is one single-port memory read one entry
// per cycle; a lookup holds the engine for a scan of the capped count, a
// wait state and a result state (result only for a count of zero) and
// while its result waits on rsp_stall. An accepted item is registered in
// the queue before the engine takes it. A two-entry request queue and a
// result register let both sides stall independently. Table slots must
// be written before a lookup covers them; the table has no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_longest_prefix_match_unit #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire ipv4_lpm_pkg::ipv4_lpm_req_type req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output ipv4_lpm_pkg::ipv4_lpm_rsp_type      rsp_data,
   input  wire logic                           csr_wr_en,
   input  wire logic [10:0]                    csr_wr_data
);
   import ipv4_lpm_pkg::*;

   logic [10:0]      entries_in_use_ff, entries_in_use_in;
   logic             q_valid;
   logic             q_pop;
   ipv4_lpm_req_type q_item;

   assign entries_in_use_in = csr_wr_en ? csr_wr_data : entries_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_in_use_ff <= 11'd0;
      end else begin
         entries_in_use_ff <= entries_in_use_in;
      end
   end

   ipv4_lpm_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   ipv4_lpm_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .entries_in_use (entries_in_use_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data)
   );

endmodule

`default_nettype wire
